[design/assert_macros.svh]
// Assertion helpers used by the region-select top level.
// Clocked, reset-gated property wrappers; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/rsel_pkg.sv]
// Package for the particle region select block: widths, codes, payload types,
// multiplier schedule. No dependencies.
`timescale 1ns / 1ps

package rsel_pkg;

   localparam int COORD_BITS     = 20;
   localparam int COUNT_BITS_DEF = 24;
   localparam int MARK_CNT_W     = 24;
   localparam int AXES           = 3;
   localparam int AXIS_W         = 2;
   localparam int POINT_W        = AXES * COORD_BITS;
   localparam int SQ_REG_W       = 43;
   localparam int SHAPE_W        = 2;
   localparam int RULE_W         = 2;
   localparam int CSR_DATA_W     = POINT_W;
   localparam int CSR_IDX_W      = 3;

   // datapath widths
   localparam int DIFF_W = COORD_BITS + 1;      // centre minus position
   localparam int LIMB_W = COORD_BITS + 2;      // half of a wide operand
   localparam int WIDE_W = 2 * LIMB_W;          // holds 43-bit regs, q2 and t
   localparam int MUL_W  = LIMB_W + 1;          // signed multiplier operand
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 2 * WIDE_W + 2;      // signed, holds r2*L + t^2 - q2*L

   localparam int CYL_STEPS = 18;
   localparam int STEP_W    = $clog2(CYL_STEPS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SET_RULE  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CLR_RULE  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_A   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_B   = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQ = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_LEN  = CSR_IDX_W'(6);

   // region shapes
   localparam logic [SHAPE_W-1:0] SHAPE_BOX    = SHAPE_W'(0);
   localparam logic [SHAPE_W-1:0] SHAPE_SPHERE = SHAPE_W'(1);
   localparam logic [SHAPE_W-1:0] SHAPE_CYL    = SHAPE_W'(2);

   // rule codes
   localparam logic [RULE_W-1:0] SET_ON  = RULE_W'(1);
   localparam logic [RULE_W-1:0] SET_OFF = RULE_W'(2);
   localparam logic [RULE_W-1:0] CLR_OFF = RULE_W'(1);
   localparam logic [RULE_W-1:0] CLR_ON  = RULE_W'(2);

   // axes
   localparam logic [AXIS_W-1:0] AX_X = AXIS_W'(0);
   localparam logic [AXIS_W-1:0] AX_Y = AXIS_W'(1);
   localparam logic [AXIS_W-1:0] AX_Z = AXIS_W'(2);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic                         old_mark;
      logic                         first_of_pass;
   } req_type;

   typedef struct packed {
      logic                  new_mark;
      logic                  inside_res;
      logic [MARK_CNT_W-1:0] marked_count;
   } rsp_type;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef diff_type [AXES-1:0]      diff_vec_type;

   typedef enum logic [3:0] {
      OP_D, OP_NEGB, OP_RLO, OP_RHI, OP_LLO, OP_LHI, OP_TLO, OP_THI, OP_QLO, OP_QHI
   } opsel_type;

   typedef enum logic [1:0] {ACC_NONE, ACC_ADD, ACC_SUB} acc_op_type;
   typedef enum logic [1:0] {SH_0, SH_1, SH_2}           shift_type;
   typedef enum logic [1:0] {FIN_NONE, FIN_Q2, FIN_T}    fin_type;

   typedef struct packed {
      opsel_type         op_a;
      opsel_type         op_b;
      logic [AXIS_W-1:0] axis;
      acc_op_type        acc_op;
      shift_type         shift;
      fin_type           fin;
   } ucode_type;

   typedef struct packed {
      logic      issue;
      logic      clr;
      ucode_type uc;
   } mac_ctl_type;

   typedef struct packed {
      logic              idle;
      logic              box_en;
      logic [AXIS_W-1:0] axis;
      logic              decide;
   } seq_stat_type;

   function automatic logic signed [COORD_BITS-1:0] coord_of(
      input logic [POINT_W-1:0] point,
      input logic [AXIS_W-1:0]  axis);
      logic signed [COORD_BITS-1:0] c;
      unique case (axis)
         AX_X:    c = point[COORD_BITS-1:0];
         AX_Y:    c = point[2*COORD_BITS-1:COORD_BITS];
         default: c = point[POINT_W-1:2*COORD_BITS];
      endcase
      return c;
   endfunction

   function automatic diff_type diff_of(input diff_vec_type v, input logic [AXIS_W-1:0] axis);
      diff_type d;
      unique case (axis)
         AX_X:    d = v[0];
         AX_Y:    d = v[1];
         default: d = v[2];
      endcase
      return d;
   endfunction

   function automatic ucode_type mk_uc(input opsel_type a, input opsel_type b,
                                       input logic [AXIS_W-1:0] ax, input acc_op_type op,
                                       input shift_type sh, input fin_type fn);
      ucode_type u;
      u.op_a   = a;
      u.op_b   = b;
      u.axis   = ax;
      u.acc_op = op;
      u.shift  = sh;
      u.fin    = fn;
      return u;
   endfunction

   // Multiplier schedule. Steps 0-2 also serve the sphere.
   // q2 = sum d^2, t = sum q.b, then acc = r2*L + t*t - q2*L in 22-bit limbs.
   function automatic ucode_type cyl_ucode(input logic [STEP_W-1:0] step);
      ucode_type u;
      unique case (int'(step))
         0:  u = mk_uc(OP_D,   OP_D,    AX_X, ACC_ADD, SH_0, FIN_NONE);
         1:  u = mk_uc(OP_D,   OP_D,    AX_Y, ACC_ADD, SH_0, FIN_NONE);
         2:  u = mk_uc(OP_D,   OP_D,    AX_Z, ACC_ADD, SH_0, FIN_Q2);
         3:  u = mk_uc(OP_D,   OP_NEGB, AX_X, ACC_ADD, SH_0, FIN_NONE);
         4:  u = mk_uc(OP_D,   OP_NEGB, AX_Y, ACC_ADD, SH_0, FIN_NONE);
         5:  u = mk_uc(OP_D,   OP_NEGB, AX_Z, ACC_ADD, SH_0, FIN_T);
         6:  u = mk_uc(OP_RLO, OP_LLO,  AX_X, ACC_ADD, SH_0, FIN_NONE);
         7:  u = mk_uc(OP_RLO, OP_LHI,  AX_X, ACC_ADD, SH_1, FIN_NONE);
         8:  u = mk_uc(OP_RHI, OP_LLO,  AX_X, ACC_ADD, SH_1, FIN_NONE);
         9:  u = mk_uc(OP_RHI, OP_LHI,  AX_X, ACC_ADD, SH_2, FIN_NONE);
         10: u = mk_uc(OP_TLO, OP_TLO,  AX_X, ACC_ADD, SH_0, FIN_NONE);
         11: u = mk_uc(OP_TLO, OP_THI,  AX_X, ACC_ADD, SH_1, FIN_NONE);
         12: u = mk_uc(OP_THI, OP_TLO,  AX_X, ACC_ADD, SH_1, FIN_NONE);
         13: u = mk_uc(OP_THI, OP_THI,  AX_X, ACC_ADD, SH_2, FIN_NONE);
         14: u = mk_uc(OP_QLO, OP_LLO,  AX_X, ACC_SUB, SH_0, FIN_NONE);
         15: u = mk_uc(OP_QLO, OP_LHI,  AX_X, ACC_SUB, SH_1, FIN_NONE);
         16: u = mk_uc(OP_QHI, OP_LLO,  AX_X, ACC_SUB, SH_1, FIN_NONE);
         17: u = mk_uc(OP_QHI, OP_LHI,  AX_X, ACC_SUB, SH_2, FIN_NONE);
         default: u = mk_uc(OP_D, OP_D, AX_X, ACC_NONE, SH_0, FIN_NONE);
      endcase
      return u;
   endfunction

endpackage

[design/particle_region_select_top.sv]
// Top level of the particle region select block: config registers, item
// registers, box check, output register. Uses rsel_pkg, rsel_seq, rsel_mac, rsel_count.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_data  (rsel_pkg::req_type)
//  rsp      out        rsp_valid / rsp_stall  rsp_data  (rsel_pkg::rsp_type)
//  csr      in         csr_wen                csr_index, csr_wdata
//
//  One particle at a time. The cylinder takes longest to reach a result: its
//  time is set by the 18-step cylinder schedule on the single 23x23 multiplier.
//  Reset (synchronous) clears config, sequencer, count and output valid.
//  A waiting result does not block the next accept; a new result is held
//  back in the decide step while the previous one is still stalled.

module particle_region_select_top #(
   parameter int COUNT_BITS = rsel_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rsel_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rsel_pkg::rsp_type                rsp_data,
   input  logic                             csr_wen,
   input  logic [rsel_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rsel_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rsel_pkg::*;

   // configuration registers
   logic [SHAPE_W-1:0]  shape_ff;
   logic [RULE_W-1:0]   set_rule_ff, clear_rule_ff;
   logic [POINT_W-1:0]  point_a_ff, point_b_ff;
   logic [SQ_REG_W-1:0] radius_sq_ff, axis_len_ff;

   // item registers
   diff_vec_type d_ff, d_in;
   logic         old_ff, first_ff;
   logic         box_ok_ff, box_ok_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic [POINT_W-1:0] pos_pack;
   logic               accept, out_free, pred, box_cond, new_mark;
   logic [MARK_CNT_W-1:0] count;
   logic [WIDE_W-1:0]  q2, t;
   logic               acc_neg;
   seq_stat_type       seq_stat;
   mac_ctl_type        mac_ctl;

   diff_type                     box_d;
   logic signed [COORD_BITS-1:0] box_h;
   logic signed [DIFF_W:0]       bd, bh, bnh;
   logic signed [COORD_BITS-1:0] ca, cp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = !seq_stat.idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // --- configuration port -------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff      <= '0;
         set_rule_ff   <= '0;
         clear_rule_ff <= '0;
         point_a_ff    <= '0;
         point_b_ff    <= '0;
         radius_sq_ff  <= '0;
         axis_len_ff   <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_SHAPE:     shape_ff      <= csr_wdata[SHAPE_W-1:0];
            CSR_SET_RULE:  set_rule_ff   <= csr_wdata[RULE_W-1:0];
            CSR_CLR_RULE:  clear_rule_ff <= csr_wdata[RULE_W-1:0];
            CSR_POINT_A:   point_a_ff    <= csr_wdata[POINT_W-1:0];
            CSR_POINT_B:   point_b_ff    <= csr_wdata[POINT_W-1:0];
            CSR_RADIUS_SQ: radius_sq_ff  <= csr_wdata[SQ_REG_W-1:0];
            CSR_AXIS_LEN:  axis_len_ff   <= csr_wdata[SQ_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // --- load: per-axis centre minus position, kept for the whole transaction
   assign pos_pack = {req_data.pos_z, req_data.pos_y, req_data.pos_x};

   always_comb begin
      ca = '0;
      cp = '0;
      for (int i = 0; i < AXES; i++) begin
         ca      = coord_of(point_a_ff, AXIS_W'(i));
         cp      = coord_of(pos_pack, AXIS_W'(i));
         d_in[i] = $signed({ca[COORD_BITS-1], ca}) - $signed({cp[COORD_BITS-1], cp});
      end
   end

   // --- box: one axis per RUN step, -half <= d < half
   always_comb begin
      box_d    = diff_of(d_ff, seq_stat.axis);
      box_h    = coord_of(point_b_ff, seq_stat.axis);
      bd       = $signed({box_d[DIFF_W-1], box_d});
      bh       = $signed({{2{box_h[COORD_BITS-1]}}, box_h});
      bnh      = -bh;
      box_cond = (bd < bh) && (bd >= bnh);
      if (accept) begin
         box_ok_in = 1'b1;
      end else if (seq_stat.box_en) begin
         box_ok_in = box_ok_ff && box_cond;
      end else begin
         box_ok_in = box_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d_ff     <= d_in;
         old_ff   <= req_data.old_mark;
         first_ff <= req_data.first_of_pass;
      end
      box_ok_ff <= box_ok_in;
   end

   // --- shared multiplier and sequencer
   rsel_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .shape    (shape_ff),
      .out_free (out_free),
      .stat     (seq_stat),
      .mac_ctl  (mac_ctl)
   );

   rsel_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mac_ctl),
      .d_vec       (d_ff),
      .point_b     (point_b_ff),
      .radius_sq   (radius_sq_ff),
      .axis_len_sq (axis_len_ff),
      .q2          (q2),
      .t           (t),
      .acc_neg     (acc_neg)
   );

   // --- region predicate, valid in the decide step
   // Cylinder: zero-length axis never selects; t must lie in [0, L];
   // acc holds r2*L + t^2 - q2*L.
   always_comb begin
      unique case (shape_ff)
         SHAPE_BOX:    pred = box_ok_ff;
         SHAPE_SPHERE: pred = (q2 <= WIDE_W'(radius_sq_ff));
         SHAPE_CYL:    pred = (axis_len_ff != '0) && !t[WIDE_W-1] &&
                              (t <= WIDE_W'(axis_len_ff)) && !acc_neg;
         default:      pred = 1'b0;
      endcase
   end

   rsel_count #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count (
      .clock         (clock),
      .reset         (reset),
      .update        (seq_stat.decide),
      .pred          (pred),
      .old_mark      (old_ff),
      .first_of_pass (first_ff),
      .set_rule      (set_rule_ff),
      .clear_rule    (clear_rule_ff),
      .new_mark      (new_mark),
      .count         (count)
   );

   // --- result register: loads on decide, drops when taken
   always_comb begin
      if (seq_stat.decide) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_stat.decide) begin
         rsp_data_ff.new_mark     <= new_mark;
         rsp_data_ff.inside_res   <= pred;
         rsp_data_ff.marked_count <= count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // --- assertions
   // an accepted transaction keeps the input stalled on the next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "input taken while busy")
   // a result appears only from a decide step
   `ASSERT_IMPLIES(a_rsp_from_decide, clock, reset, $rose(rsp_valid), $past(seq_stat.decide), "result without decide")
   // decide never overwrites a stalled result
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, seq_stat.decide, !(rsp_valid && rsp_stall), "stalled result overwritten")

endmodule

[design/rsel_mac.sv]
// Shared multiply-accumulate unit: one 23x23 signed multiplier, product
// register, shifting 90-bit accumulator and q2 / t holding registers. Uses rsel_pkg.
`timescale 1ns / 1ps

module rsel_mac (
   input  logic                            clock,
   input  logic                            reset,
   input  rsel_pkg::mac_ctl_type           ctl,
   input  rsel_pkg::diff_vec_type          d_vec,
   input  logic [rsel_pkg::POINT_W-1:0]    point_b,
   input  logic [rsel_pkg::SQ_REG_W-1:0]   radius_sq,
   input  logic [rsel_pkg::SQ_REG_W-1:0]   axis_len_sq,
   output logic [rsel_pkg::WIDE_W-1:0]     q2,
   output logic [rsel_pkg::WIDE_W-1:0]     t,
   output logic                            acc_neg
);
   import rsel_pkg::*;

   logic signed [MUL_W-1:0]  opa, opb;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   ucode_type                pend_ff, pend_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, addend, addend_sh, sum;
   logic [WIDE_W-1:0]        q2_ff, q2_in, t_ff, t_in;
   logic [WIDE_W-1:0]        r_w, l_w;
   diff_type                 d_ax;
   logic signed [COORD_BITS-1:0] b_ax;
   logic signed [MUL_W-1:0]  d_ext, nb_ext;

   function automatic logic signed [MUL_W-1:0] pick_op(
      input opsel_type sel, input logic signed [MUL_W-1:0] dv,
      input logic signed [MUL_W-1:0] nbv, input logic [WIDE_W-1:0] rv,
      input logic [WIDE_W-1:0] lv, input logic [WIDE_W-1:0] qv,
      input logic [WIDE_W-1:0] tv);
      logic signed [MUL_W-1:0] o;
      unique case (sel)
         OP_D:    o = dv;
         OP_NEGB: o = nbv;
         OP_RLO:  o = $signed({1'b0, rv[LIMB_W-1:0]});
         OP_RHI:  o = $signed({1'b0, rv[WIDE_W-1:LIMB_W]});
         OP_LLO:  o = $signed({1'b0, lv[LIMB_W-1:0]});
         OP_LHI:  o = $signed({1'b0, lv[WIDE_W-1:LIMB_W]});
         OP_TLO:  o = $signed({1'b0, tv[LIMB_W-1:0]});
         OP_THI:  o = $signed({1'b0, tv[WIDE_W-1:LIMB_W]});
         OP_QLO:  o = $signed({1'b0, qv[LIMB_W-1:0]});
         OP_QHI:  o = $signed({1'b0, qv[WIDE_W-1:LIMB_W]});
         default: o = '0;
      endcase
      return o;
   endfunction

   // operand selection and multiply
   always_comb begin
      r_w    = WIDE_W'(radius_sq);
      l_w    = WIDE_W'(axis_len_sq);
      d_ax   = diff_of(d_vec, ctl.uc.axis);
      b_ax   = coord_of(point_b, ctl.uc.axis);
      d_ext  = $signed({{(MUL_W-DIFF_W){d_ax[DIFF_W-1]}}, d_ax});
      nb_ext = $signed(MUL_W'(0)) - $signed({{(MUL_W-COORD_BITS){b_ax[COORD_BITS-1]}}, b_ax});
      opa    = pick_op(ctl.uc.op_a, d_ext, nb_ext, r_w, l_w, q2_ff, t_ff);
      opb    = pick_op(ctl.uc.op_b, d_ext, nb_ext, r_w, l_w, q2_ff, t_ff);
      prod_in = opa * opb;
      pend_in = ctl.uc;
      if (!ctl.issue) begin
         pend_in.acc_op = ACC_NONE;
      end
   end

   // accumulate the previous product, held in the product register
   always_comb begin
      addend = $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
      unique case (pend_ff.shift)
         SH_1:    addend_sh = addend <<< LIMB_W;
         SH_2:    addend_sh = addend <<< (2 * LIMB_W);
         default: addend_sh = addend;
      endcase
      sum   = (pend_ff.acc_op == ACC_SUB) ? acc_ff - addend_sh : acc_ff + addend_sh;
      acc_in = acc_ff;
      q2_in  = q2_ff;
      t_in   = t_ff;
      if (ctl.clr) begin
         acc_in = '0;
      end else if (pend_ff.acc_op != ACC_NONE) begin
         unique case (pend_ff.fin)
            FIN_Q2: begin
               q2_in  = sum[WIDE_W-1:0];
               acc_in = '0;
            end
            FIN_T: begin
               t_in   = sum[WIDE_W-1:0];
               acc_in = '0;
            end
            default: acc_in = sum;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      q2_ff   <= q2_in;
      t_ff    <= t_in;
   end

   assign q2      = q2_ff;
   assign t       = t_ff;
   assign acc_neg = acc_ff[ACC_W-1];

endmodule

[design/rsel_seq.sv]
// Sequencer: one-hot state machine and step counter that drive the shared
// multiply-accumulate unit and the box check. Uses rsel_pkg.
`timescale 1ns / 1ps

module rsel_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [rsel_pkg::SHAPE_W-1:0] shape,
   input  logic                         out_free,
   output rsel_pkg::seq_stat_type       stat,
   output rsel_pkg::mac_ctl_type        mac_ctl
);
   import rsel_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in, last_step;
   logic              uses_mac;

   always_comb begin
      unique case (shape)
         SHAPE_BOX, SHAPE_SPHERE: last_step = STEP_W'(AXES - 1);
         SHAPE_CYL:               last_step = STEP_W'(CYL_STEPS - 1);
         default:                 last_step = '0;
      endcase
      uses_mac = (shape == SHAPE_SPHERE) || (shape == SHAPE_CYL);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (step_ff == last_step) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      stat.idle     = (state_ff == ST_IDLE);
      stat.box_en   = (state_ff == ST_RUN) && (shape == SHAPE_BOX);
      stat.axis     = step_ff[AXIS_W-1:0];
      stat.decide   = (state_ff == ST_DECIDE) && out_free;
      mac_ctl.issue = (state_ff == ST_RUN) && uses_mac;
      mac_ctl.clr   = load;
      mac_ctl.uc    = cyl_ucode(step_ff);
   end

endmodule

[design/rsel_count.sv]
// Mark rules and saturating running mark count.
// Uses rsel_pkg; counter width set by COUNT_BITS, count output MARK_CNT_W bits wide.
`timescale 1ns / 1ps

module rsel_count #(
   parameter int COUNT_BITS = rsel_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            update,
   input  logic                            pred,
   input  logic                            old_mark,
   input  logic                            first_of_pass,
   input  logic [rsel_pkg::RULE_W-1:0]     set_rule,
   input  logic [rsel_pkg::RULE_W-1:0]     clear_rule,
   output logic                            new_mark,
   output logic [rsel_pkg::MARK_CNT_W-1:0] count
);
   import rsel_pkg::*;

   localparam int EXT_W = (COUNT_BITS > MARK_CNT_W) ? COUNT_BITS : MARK_CNT_W;

   logic [COUNT_BITS-1:0] total_ff, total_in, base, cnt_next;
   logic [EXT_W-1:0]      cnt_ext;
   logic                  mark;

   always_comb begin
      if (pred) begin
         unique case (set_rule)
            SET_ON:  mark = 1'b1;
            SET_OFF: mark = 1'b0;
            default: mark = old_mark;
         endcase
      end else begin
         unique case (clear_rule)
            CLR_OFF: mark = 1'b0;
            CLR_ON:  mark = 1'b1;
            default: mark = old_mark;
         endcase
      end
      base     = first_of_pass ? '0 : total_ff;
      cnt_next = (mark && !(&base)) ? base + COUNT_BITS'(1) : base;
      total_in = update ? cnt_next : total_ff;
      cnt_ext  = EXT_W'(cnt_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign new_mark = mark;
   assign count    = cnt_ext[MARK_CNT_W-1:0];

endmodule
